// File: rtl/core/frd_pkg.sv
`default_nettype none

package frd_pkg;

	localparam int PANEL_W     = 240;
	localparam int PANEL_H     = 240;
	localparam int STORE_DEPTH = PANEL_W * PANEL_H;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int PIX_W       = 32;
	localparam int COORD_W     = 8;
	localparam int CFG_IDX_W   = 3;

	localparam logic [PIX_W-1:0] STORE_RESET = 32'hA5A5_A5A5;
	localparam logic [PIX_W-1:0] NARROW_MASK = 32'h0000_FFFF;

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [ADDR_W-1:0]  addr_t;
	typedef logic [PIX_W-1:0]   pix_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 3'd0,
		REG_FRAME_HEIGHT = 3'd1,
		REG_Y_OFFSET     = 3'd2,
		REG_WIDE_PIXELS  = 3'd3,
		REG_FULL_FRAME   = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		coord_t frame_width;
		coord_t frame_height;
		coord_t y_offset;
		logic   wide_pixels;
		logic   full_frame_mode;
	} cfg_t;

	typedef struct packed {
		logic   valid;
		logic   in_area;
		logic   frame_start;
		logic   last;
		coord_t x;
		coord_t y;
		addr_t  addr;
		pix_t   value;
		logic   wide;
	} item_t;

	typedef struct packed {
		logic   en;
		addr_t  addr;
		pix_t   data;
	} wr_t;

	typedef struct packed {
		logic   changed;
		coord_t x_start;
		coord_t y_start;
		coord_t x_end;
		coord_t y_end;
	} result_t;

	function automatic coord_t copy_cols(cfg_t c);
		return (c.frame_width < COORD_W'(PANEL_W)) ? c.frame_width : COORD_W'(PANEL_W);
	endfunction

	function automatic coord_t copy_rows(cfg_t c);
		coord_t room;
		room = COORD_W'(PANEL_H) - c.y_offset;
		if (c.y_offset >= COORD_W'(PANEL_H))
			return '0;
		return (c.frame_height < room) ? c.frame_height : room;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/frd_store.sv
`default_nettype none

module frd_store import frd_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  rd_en,
	input  wire addr_t rd_addr,
	input  wire wr_t   wr,
	output pix_t       rd_data,
	output logic       busy
);

	pix_t  mem [STORE_DEPTH];
	pix_t  mem_rd_q;
	pix_t  fwd_data_q;
	logic  fwd_q;
	logic  busy_q;
	addr_t clr_addr_q;
	logic  we;
	addr_t wa;
	pix_t  wd;

	always_comb begin
		we = busy_q | wr.en;
		wa = busy_q ? clr_addr_q : wr.addr;
		wd = busy_q ? STORE_RESET : wr.data;
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[wa] <= wd;
		if (rd_en) begin
			mem_rd_q   <= mem[rd_addr];
			fwd_data_q <= wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b1;
			clr_addr_q <= '0;
			fwd_q      <= 1'b0;
		end else begin
			if (busy_q) begin
				if (clr_addr_q == ADDR_W'(STORE_DEPTH - 1))
					busy_q <= 1'b0;
				else
					clr_addr_q <= clr_addr_q + 1'b1;
			end
			// take the word being written this cycle when the read hits it
			if (rd_en)
				fwd_q <= wr.en && (wr.addr == rd_addr);
		end
	end

	assign rd_data = fwd_q ? fwd_data_q : mem_rd_q;
	assign busy    = busy_q;

endmodule

`default_nettype wire

// File: rtl/core/frd_track.sv
`default_nettype none

module frd_track import frd_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire item_t s1,
	input  wire pix_t  rd_data,
	input  wire cfg_t  cfg,
	output wr_t        wr,
	output logic       res_push,
	output result_t    res
);

	coord_t rmin_q, rmax_q, cmin_q, cmax_q;
	logic   any_q;
	coord_t rmin_b, rmax_b, cmin_b, cmax_b;
	logic   any_b;
	coord_t rmin_n, rmax_n, cmin_n, cmax_n;
	logic   any_n;
	pix_t   mask;
	logic   dirty;
	coord_t cw, ch;

	always_comb begin
		if (s1.frame_start) begin
			rmin_b = '1;
			rmax_b = '0;
			cmin_b = '1;
			cmax_b = '0;
			any_b  = 1'b0;
		end else begin
			rmin_b = rmin_q;
			rmax_b = rmax_q;
			cmin_b = cmin_q;
			cmax_b = cmax_q;
			any_b  = any_q;
		end

		mask  = s1.wide ? '1 : NARROW_MASK;
		dirty = s1.in_area && (((rd_data & mask) ^ s1.value) != '0);

		rmin_n = rmin_b;
		rmax_n = rmax_b;
		cmin_n = cmin_b;
		cmax_n = cmax_b;
		any_n  = any_b;
		if (dirty) begin
			if (s1.y < rmin_b)
				rmin_n = s1.y;
			if (s1.y > rmax_b || !any_b)
				rmax_n = s1.y;
			if (s1.x < cmin_b)
				cmin_n = s1.x;
			if (s1.x > cmax_b || !any_b)
				cmax_n = s1.x;
			any_n = 1'b1;
		end

		cw  = copy_cols(cfg);
		ch  = copy_rows(cfg);
		res = '0;
		if (cfg.full_frame_mode) begin
			if (cw != '0 && ch != '0) begin
				res.changed = 1'b1;
				res.x_start = '0;
				res.y_start = cfg.y_offset;
				res.x_end   = cw - 1'b1;
				res.y_end   = cfg.y_offset + ch - 1'b1;
			end
		end else if (any_n) begin
			res.changed = 1'b1;
			res.x_start = cmin_n;
			res.y_start = rmin_n + cfg.y_offset;
			res.x_end   = cmax_n;
			res.y_end   = rmax_n + cfg.y_offset;
		end

		res_push = s1.valid && s1.last;
		wr.en    = s1.valid && s1.in_area;
		wr.addr  = s1.addr;
		wr.data  = s1.value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rmin_q <= '1;
			rmax_q <= '0;
			cmin_q <= '1;
			cmax_q <= '0;
			any_q  <= 1'b0;
		end else if (s1.valid) begin
			if (s1.last) begin
				rmin_q <= '1;
				rmax_q <= '0;
				cmin_q <= '1;
				cmax_q <= '0;
				any_q  <= 1'b0;
			end else begin
				rmin_q <= rmin_n;
				rmax_q <= rmax_n;
				cmin_q <= cmin_n;
				cmax_q <= cmax_n;
				any_q  <= any_n;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/frd_out_fifo.sv
`default_nettype none

module frd_out_fifo import frd_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire result_t push_data,
	output logic         out_valid,
	input  wire logic    out_ready,
	output result_t      out_data,
	output logic [1:0]   count
);

	result_t    ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign out_valid = (cnt_q != 2'd0);
	assign pop       = out_valid && out_ready;
	assign out_data  = ent_q[rd_ptr_q];
	assign count     = cnt_q;

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/frame_dirty_rect_detect.sv
`default_nettype none

// Frame dirty-rectangle detector.
// Input channel (in_valid/in_ready): one pixel per transfer in raster order,
// frame_start marks the first pixel of a frame. Each pixel inside the copy
// area is compared with the stored previous frame and written back.
// Output channel (out_valid/out_ready): one result per frame, a changed flag
// and the bounding rectangle in panel rows. The result passes the stage-1
// register and the result queue after the transfer of the last pixel of the
// frame, and waits behind an earlier result that still sits in the queue.
// Throughput: one pixel per cycle while in_ready is high; each pixel does one
// read and one write-back of the single-port-per-direction frame store, with
// same-address forwarding when consecutive pixels hit the same entry.
// Configuration (cfg_valid/cfg_ready): always ready, index selects register.
// Reset: the store is filled with 0xA5 bytes, all 57600 words, one word per
// cycle; in_ready stays low meanwhile, configuration writes are still taken.
// Stall: a two-entry result queue absorbs results; pixels keep flowing while
// one result waits, and in_ready drops while two results are queued or about
// to be queued.

module frame_dirty_rect_detect import frd_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [COORD_W-1:0]   cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [PIX_W-1:0]     pixel,
	input  wire logic                 frame_start,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic                      changed,
	output logic [COORD_W-1:0]        x_start,
	output logic [COORD_W-1:0]        y_start,
	output logic [COORD_W-1:0]        x_end,
	output logic [COORD_W-1:0]        y_end
);

	cfg_t       cfg_q;
	coord_t     x_q, y_q;
	item_t      item_s1;
	item_t      item_s0;
	logic       accept;
	logic       row_end, frame_end;
	coord_t     cw, ch;
	pix_t       rd_data;
	logic       busy;
	wr_t        wr;
	logic       res_push;
	result_t    res;
	result_t    out_data;
	logic [1:0] fifo_cnt;
	logic [2:0] occupancy;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width     <= 8'd240;
			cfg_q.frame_height    <= 8'd175;
			cfg_q.y_offset        <= 8'd65;
			cfg_q.wide_pixels     <= 1'b1;
			cfg_q.full_frame_mode <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_FRAME_WIDTH:  cfg_q.frame_width     <= cfg_data;
				REG_FRAME_HEIGHT: cfg_q.frame_height    <= cfg_data;
				REG_Y_OFFSET:     cfg_q.y_offset        <= cfg_data;
				REG_WIDE_PIXELS:  cfg_q.wide_pixels     <= cfg_data[0];
				REG_FULL_FRAME:   cfg_q.full_frame_mode <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign occupancy = {1'b0, fifo_cnt} + {2'b00, item_s1.valid && item_s1.last};
	assign in_ready  = !busy && (occupancy < 3'd2);
	assign accept    = in_valid && in_ready;

	always_comb begin
		cw = copy_cols(cfg_q);
		ch = copy_rows(cfg_q);

		item_s0.valid       = accept;
		item_s0.frame_start = frame_start;
		item_s0.x           = frame_start ? '0 : x_q;
		item_s0.y           = frame_start ? '0 : y_q;
		item_s0.in_area     = (item_s0.x < cw) && (item_s0.y < ch);
		item_s0.addr        = ADDR_W'(item_s0.y) * ADDR_W'(PANEL_W) + ADDR_W'(item_s0.x);
		item_s0.wide        = cfg_q.wide_pixels;
		item_s0.value       = pixel & (cfg_q.wide_pixels ? '1 : NARROW_MASK);

		row_end   = ({1'b0, item_s0.x} + 9'd1) >= {1'b0, cfg_q.frame_width};
		frame_end = row_end && (({1'b0, item_s0.y} + 9'd1) >= {1'b0, cfg_q.frame_height});
		item_s0.last = frame_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q     <= '0;
			y_q     <= '0;
			item_s1 <= '0;
		end else begin
			item_s1 <= item_s0;
			if (accept) begin
				if (row_end) begin
					x_q <= '0;
					y_q <= frame_end ? '0 : item_s0.y + 1'b1;
				end else begin
					x_q <= item_s0.x + 1'b1;
					y_q <= item_s0.y;
				end
			end
		end
	end

	frd_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (item_s0.addr),
		.wr      (wr),
		.rd_data (rd_data),
		.busy    (busy)
	);

	frd_track u_track (
		.clk      (clk),
		.arst_n   (arst_n),
		.s1       (item_s1),
		.rd_data  (rd_data),
		.cfg      (cfg_q),
		.wr       (wr),
		.res_push (res_push),
		.res      (res)
	);

	frd_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_data (res),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.count     (fifo_cnt)
	);

	assign changed = out_data.changed;
	assign x_start = out_data.x_start;
	assign y_start = out_data.y_start;
	assign x_end   = out_data.x_end;
	assign y_end   = out_data.y_end;

`ifndef SYNTH
	a_no_pixel_during_fill: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !in_ready)
		else $error("pixel accepted while store fill runs");

	a_result_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> (fifo_cnt < 2'd2))
		else $error("result pushed into full queue");

	a_write_only_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> $past(accept))
		else $error("store write-back without a preceding read");
`endif

endmodule

`default_nettype wire
